[rtl/core/tile_slot_group_allocator_defines.svh]
// assertion helpers for the allocator rtl
`ifndef TILE_SLOT_GROUP_ALLOCATOR_DEFINES_SVH
`define TILE_SLOT_GROUP_ALLOCATOR_DEFINES_SVH

// clocked property, off while in reset
`define TSGA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define TSGA_NEVER(label, expr, msg) \
    `TSGA_ASSERT(label, !(expr), msg)

`endif

[rtl/core/tsga_pkg.sv]
package tsga_pkg;

    localparam int GROUPS_DEF    = 64;
    localparam int MAX_SLOTS_DEF = 256;

    localparam int CFG_W       = 9;
    localparam int CMD_W       = 2;
    localparam int ID_W        = 25;
    localparam int GF_W        = 16;
    localparam int SF_W        = 9;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 9;
    localparam int STATUS_W    = 2;
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_OFF_W = 3;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 9'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_RCL_EMPTY = 2'd2,
        CMD_RCL_ALL   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        logic                   hit_free;
        logic [CHUNK_OFF_W-1:0] free_off;
        logic                   any_absent;
        logic [CHUNK_OFF_W-1:0] absent_off;
    } scan_res_t;

    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

[rtl/core/tsga_scan.sv]
module tsga_scan
    import tsga_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    localparam int NCHUNK = (GROUPS + CHUNK_W - 1) / CHUNK_W,
    localparam int CIDX_W = idx_w(NCHUNK)
)
(
    input  logic [GROUPS-1:0] present,
    input  logic [GROUPS-1:0] has_free,
    input  logic [CIDX_W-1:0] chunk,
    output scan_res_t         res
);

    localparam int PAD_W = NCHUNK * CHUNK_W;

    logic [PAD_W-1:0]   pres_pad;
    logic [PAD_W-1:0]   free_pad;
    logic [CHUNK_W-1:0] pres_c;
    logic [CHUNK_W-1:0] free_c;

    // pad groups read as present with nothing free
    always_comb
    begin
        pres_pad = '1;
        free_pad = '0;
        pres_pad[GROUPS-1:0] = present;
        free_pad[GROUPS-1:0] = has_free;
    end

    assign pres_c = pres_pad[{chunk, {CHUNK_OFF_W{1'b0}}} +: CHUNK_W];
    assign free_c = free_pad[{chunk, {CHUNK_OFF_W{1'b0}}} +: CHUNK_W];

    always_comb
    begin
        res = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            if (free_c[i])
            begin
                res.hit_free = 1'b1;
                res.free_off = CHUNK_OFF_W'(i);
            end
        end
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            if (!pres_c[i])
            begin
                res.any_absent = 1'b1;
                res.absent_off = CHUNK_OFF_W'(i);
            end
        end
    end

endmodule

[rtl/core/tsga_store.sv]
module tsga_store
    import tsga_pkg::*;
#(
    parameter int GROUPS    = GROUPS_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    localparam int GW       = idx_w(GROUPS),
    localparam int SIDX_W   = idx_w(MAX_SLOTS)
)
(
    input  logic                   clk,
    input  logic [GW-1:0]          cnt_rd_grp,
    output logic [CNT_W-1:0]       cnt_rdata,
    input  logic                   cnt_we,
    input  logic [GW-1:0]          cnt_wgrp,
    input  logic [CNT_W-1:0]       cnt_wdata,
    input  logic [GW+SIDX_W-1:0]   stk_rd_addr,
    output logic [SLOT_W-1:0]      stk_rdata,
    input  logic                   stk_we,
    input  logic [GW+SIDX_W-1:0]   stk_waddr,
    input  logic [SLOT_W-1:0]      stk_wdata
);

    localparam int STK_DEPTH = 2 ** (GW + SIDX_W);

    logic [CNT_W-1:0]  count_mem [0:GROUPS-1];
    logic [SLOT_W-1:0] stack_mem [0:STK_DEPTH-1];
    logic [CNT_W-1:0]  cnt_rdata_reg;
    logic [SLOT_W-1:0] stk_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            count_mem[cnt_wgrp] <= cnt_wdata;
        cnt_rdata_reg <= count_mem[cnt_rd_grp];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        stk_rdata_reg <= stack_mem[stk_rd_addr];
    end

    assign cnt_rdata = cnt_rdata_reg;
    assign stk_rdata = stk_rdata_reg;

endmodule

[rtl/core/tile_slot_group_allocator.sv]
// Tile slot allocator with one LIFO free stack per group of slots. One request at a
// time; a finished result waits in the output register while the next request is
// taken. A free whose group or slot field is rejected at once goes straight to the response.
// Allocate scans the present and free-slot flags eight groups a cycle, from the top
// down, then reads the count and the stack. Opening a new group scans every chunk and
// then writes its stack one entry a cycle; a full table is answered only after every
// chunk is scanned. Reclaim of empty groups reads every group's count in turn; reclaim
// of all groups clears every presence and free flag. A result still stalled in the
// output register keeps the block in its response state until it is taken.
// The stack memory needs no clearing after reset; group presence flags mark which
// counts are live.
`include "tile_slot_group_allocator_defines.svh"

module tile_slot_group_allocator
    import tsga_pkg::*;
#(
    parameter int GROUPS    = GROUPS_DEF,
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ID_W-1:0]     tile_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     tile_id_out,
    output logic [STATUS_W-1:0] status
);

    localparam int GW     = idx_w(GROUPS);
    localparam int SIDX_W = idx_w(MAX_SLOTS);
    localparam int NCHUNK = (GROUPS + CHUNK_W - 1) / CHUNK_W;
    localparam int CIDX_W = idx_w(NCHUNK);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_POP_CNT,
        S_POP_RD,
        S_POP_OUT,
        S_FILL,
        S_FREE_CNT,
        S_FREE_WR,
        S_RCL_RD,
        S_RCL_CHK,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      cfg_reg, cfg_next;
    logic [GROUPS-1:0]     present_reg, present_next;
    logic [GROUPS-1:0]     has_free_reg, has_free_next;
    logic [GW-1:0]         grp_reg, grp_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [CIDX_W-1:0]     chunk_reg, chunk_next;
    logic [GW-1:0]         abs_grp_reg, abs_grp_next;
    logic                  abs_found_reg, abs_found_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic [STATUS_W-1:0]   res_st_reg, res_st_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ID_W-1:0]       tile_id_out_reg, tile_id_out_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic [CNT_W-1:0]      n_eff;
    logic [GF_W-1:0]       gf;
    logic [SF_W-1:0]       sf;
    logic [GW-1:0]         gf_idx;
    logic                  free_ok;
    scan_res_t             scan;
    logic [GW-1:0]         scan_free_grp;
    logic [GW-1:0]         scan_abs_grp;

    logic [CNT_W-1:0]      cnt_rdata;
    logic                  cnt_we;
    logic [CNT_W-1:0]      cnt_wdata;
    logic [GW+SIDX_W-1:0]  stk_rd_addr;
    logic [SLOT_W-1:0]     stk_rdata;
    logic                  stk_we;
    logic [GW+SIDX_W-1:0]  stk_waddr;
    logic [SLOT_W-1:0]     stk_wdata;

    function automatic logic [ID_W-1:0] encode_id(input logic [GW-1:0] g,
                                                  input logic [SLOT_W-1:0] s);
        logic [GF_W-1:0] gp;
        logic [SF_W-1:0] sp;
        gp = GF_W'(g) + GF_W'(1);
        sp = SF_W'(s) + SF_W'(1);
        return {sp, gp};
    endfunction

    tsga_scan #(
        .GROUPS   (GROUPS)
    ) u_scan (
        .present  (present_reg),
        .has_free (has_free_reg),
        .chunk    (chunk_reg),
        .res      (scan)
    );

    tsga_store #(
        .GROUPS      (GROUPS),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_store (
        .clk         (clk),
        .cnt_rd_grp  (grp_reg),
        .cnt_rdata   (cnt_rdata),
        .cnt_we      (cnt_we),
        .cnt_wgrp    (grp_reg),
        .cnt_wdata   (cnt_wdata),
        .stk_rd_addr (stk_rd_addr),
        .stk_rdata   (stk_rdata),
        .stk_we      (stk_we),
        .stk_waddr   (stk_waddr),
        .stk_wdata   (stk_wdata)
    );

    // register value 0 acts as 1, above the slot limit as the limit
    always_comb
    begin
        if (cfg_reg == '0)
            n_eff = CNT_W'(1);
        else if (cfg_reg > CFG_W'(MAX_SLOTS))
            n_eff = CNT_W'(MAX_SLOTS);
        else
            n_eff = cfg_reg;
    end

    assign gf      = tile_id[GF_W-1:0];
    assign sf      = tile_id[ID_W-1:GF_W];
    assign gf_idx  = GW'(gf - GF_W'(1));
    assign free_ok = (gf != '0) && (gf <= GF_W'(GROUPS)) && (sf != '0)
                     && ((sf - SF_W'(1)) < n_eff) && present_reg[gf_idx];

    assign scan_free_grp = GW'({chunk_reg, scan.free_off});
    assign scan_abs_grp  = GW'({chunk_reg, scan.absent_off});

    assign stk_rd_addr = {grp_reg, SIDX_W'(cnt_rdata - CNT_W'(1))};

    always_comb
    begin
        state_next       = state_reg;
        cfg_next         = cfg_reg;
        present_next     = present_reg;
        has_free_next    = has_free_reg;
        grp_next         = grp_reg;
        slot_next        = slot_reg;
        chunk_next       = chunk_reg;
        abs_grp_next     = abs_grp_reg;
        abs_found_next   = abs_found_reg;
        fill_next        = fill_reg;
        res_id_next      = res_id_reg;
        res_st_next      = res_st_reg;
        out_valid_next   = out_valid_reg && out_stall;
        tile_id_out_next = tile_id_out_reg;
        status_next      = status_reg;
        cnt_we           = 1'b0;
        cnt_wdata        = cnt_rdata;
        stk_we           = 1'b0;
        stk_waddr        = {grp_reg, SIDX_W'(fill_reg - CNT_W'(1))};
        stk_wdata        = SLOT_W'(fill_reg);

        if (cfg_wr_en)
            cfg_next = cfg_wr_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_id_next = '0;
                    res_st_next = ST_OK;
                    case (cmd_t'(cmd))
                        CMD_ALLOC:
                        begin
                            chunk_next     = CIDX_W'(NCHUNK - 1);
                            abs_found_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        CMD_FREE:
                        begin
                            if (free_ok)
                            begin
                                grp_next   = gf_idx;
                                slot_next  = SLOT_W'(sf - SF_W'(1));
                                state_next = S_FREE_CNT;
                            end
                            else
                            begin
                                res_st_next = ST_BAD;
                                state_next  = S_RESP;
                            end
                        end
                        CMD_RCL_EMPTY:
                        begin
                            grp_next   = '0;
                            state_next = S_RCL_RD;
                        end
                        default:
                        begin
                            present_next  = '0;
                            has_free_next = '0;
                            state_next    = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (scan.hit_free)
                begin
                    grp_next   = scan_free_grp;
                    state_next = S_POP_CNT;
                end
                else
                begin
                    if (scan.any_absent)
                    begin
                        abs_grp_next   = scan_abs_grp;
                        abs_found_next = 1'b1;
                    end
                    if (chunk_reg == '0)
                    begin
                        if (scan.any_absent || abs_found_reg)
                        begin
                            grp_next   = scan.any_absent ? scan_abs_grp : abs_grp_reg;
                            fill_next  = CNT_W'(1);
                            state_next = S_FILL;
                        end
                        else
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                    end
                    else
                    begin
                        chunk_next = chunk_reg - CIDX_W'(1);
                    end
                end
            end

            S_POP_CNT:
            begin
                state_next = S_POP_RD;
            end

            // stack read issued this cycle, count drops by one
            S_POP_RD:
            begin
                cnt_we                 = 1'b1;
                cnt_wdata              = cnt_rdata - CNT_W'(1);
                has_free_next[grp_reg] = (cnt_rdata != CNT_W'(1));
                state_next             = S_POP_OUT;
            end

            S_POP_OUT:
            begin
                res_id_next = encode_id(grp_reg, stk_rdata);
                state_next  = S_RESP;
            end

            // fresh group: stack holds slots 1..n-1, slot 0 goes out
            S_FILL:
            begin
                if (fill_reg >= n_eff)
                begin
                    cnt_we                 = 1'b1;
                    cnt_wdata              = n_eff - CNT_W'(1);
                    present_next[grp_reg]  = 1'b1;
                    has_free_next[grp_reg] = (n_eff != CNT_W'(1));
                    res_id_next            = encode_id(grp_reg, '0);
                    state_next             = S_RESP;
                end
                else
                begin
                    stk_we    = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end

            S_FREE_CNT:
            begin
                state_next = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                if (cnt_rdata >= n_eff)
                begin
                    res_st_next = ST_BAD;
                end
                else
                begin
                    stk_we                 = 1'b1;
                    stk_waddr              = {grp_reg, SIDX_W'(cnt_rdata)};
                    stk_wdata              = slot_reg;
                    cnt_we                 = 1'b1;
                    cnt_wdata              = cnt_rdata + CNT_W'(1);
                    has_free_next[grp_reg] = 1'b1;
                end
                state_next = S_RESP;
            end

            S_RCL_RD:
            begin
                state_next = S_RCL_CHK;
            end

            S_RCL_CHK:
            begin
                if (present_reg[grp_reg] && (cnt_rdata == n_eff))
                begin
                    present_next[grp_reg]  = 1'b0;
                    has_free_next[grp_reg] = 1'b0;
                end
                if (grp_reg == GW'(GROUPS - 1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    grp_next   = grp_reg + GW'(1);
                    state_next = S_RCL_RD;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    tile_id_out_next = res_id_reg;
                    status_next      = res_st_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cfg_reg         <= SLOTS_RESET;
            present_reg     <= '0;
            has_free_reg    <= '0;
            abs_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            tile_id_out_reg <= '0;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            cfg_reg         <= cfg_next;
            present_reg     <= present_next;
            has_free_reg    <= has_free_next;
            abs_found_reg   <= abs_found_next;
            out_valid_reg   <= out_valid_next;
            tile_id_out_reg <= tile_id_out_next;
            status_reg      <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg         <= grp_next;
        slot_reg        <= slot_next;
        chunk_reg       <= chunk_next;
        abs_grp_reg     <= abs_grp_next;
        fill_reg        <= fill_next;
        res_id_reg      <= res_id_next;
        res_st_reg      <= res_st_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign tile_id_out = tile_id_out_reg;
    assign status      = status_reg;

    `TSGA_NEVER(a_free_needs_present, |(has_free_reg & ~present_reg), "free flag on absent group")
    `TSGA_ASSERT(a_pop_nonempty, (state_reg == S_POP_RD) |-> (cnt_rdata != '0), "pop from empty stack")
    `TSGA_ASSERT(a_fill_bounded, (state_reg == S_FILL) |-> (fill_reg <= n_eff), "fill ran past group size")
    `TSGA_ASSERT(a_resp_hands_off, (state_reg == S_RESP && (!out_valid_reg || !out_stall)) |=> (state_reg == S_IDLE && out_valid_reg), "result not handed to output")
    `TSGA_ASSERT(a_full_gives_zero, (out_valid_reg && status_reg == ST_FULL) |-> (tile_id_out_reg == '0), "nonzero id on full table")

endmodule

[test/tile_slot_group_allocator_checker.sv]
`timescale 1ns / 100ps

module tile_slot_group_allocator_checker
    import tsga_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ID_W-1:0]     tile_id,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [ID_W-1:0]     tile_id_out,
    input  logic [STATUS_W-1:0] status,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  full_seen,
    output int                  bad_seen
);

    localparam int GROUPS    = GROUPS_DEF;
    localparam int MAX_SLOTS = MAX_SLOTS_DEF;

    typedef struct {
        logic [ID_W-1:0] id;
        status_t         st;
    } tile_result_t;

    logic                group_live [GROUPS];
    logic [CNT_W-1:0]    free_depth [GROUPS];
    logic [SLOT_W-1:0]   slot_stack [GROUPS][MAX_SLOTS];
    logic [CFG_W-1:0]    slots_cfg;
    tile_result_t        expected_q [$];

    function automatic int usable_slots();
        if (slots_cfg == 0)
            return 1;
        if (slots_cfg > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(slots_cfg);
    endfunction

    function automatic logic [ID_W-1:0] encode_tile(input int g, input int slot);
        return ID_W'(g + 1) | (ID_W'(slot + 1) << GF_W);
    endfunction

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic predict_request(input cmd_t op, input logic [ID_W-1:0] id,
                                   output tile_result_t r);
        int n;
        int g;
        int c;
        int s;
        bit done;
        logic [GF_W-1:0] gf;
        logic [SF_W-1:0] sf;
        n = usable_slots();
        r.id = '0;
        r.st = ST_OK;
        done = 0;
        case (op)
            CMD_ALLOC:
            begin
                for (g = GROUPS - 1; g >= 0 && !done; g--)
                begin
                    if (group_live[g] && free_depth[g] != 0)
                    begin
                        c = int'(free_depth[g]) - 1;
                        r.id = encode_tile(g, int'(slot_stack[g][c]));
                        free_depth[g] = CNT_W'(c);
                        done = 1;
                    end
                end
                for (g = 0; g < GROUPS && !done; g++)
                begin
                    if (!group_live[g])
                    begin
                        for (s = 1; s < n; s++)
                            slot_stack[g][s - 1] = SLOT_W'(s);
                        free_depth[g] = CNT_W'(n - 1);
                        group_live[g] = 1'b1;
                        r.id = encode_tile(g, 0);
                        done = 1;
                    end
                end
                if (!done)
                    r.st = ST_FULL;
            end
            CMD_FREE:
            begin
                gf = id[GF_W-1:0];
                sf = id[ID_W-1:GF_W];
                r.st = ST_BAD;
                if (gf != 0 && gf <= GROUPS && sf != 0)
                begin
                    g = int'(gf) - 1;
                    s = int'(sf) - 1;
                    c = int'(free_depth[g]);
                    if (group_live[g] && s < n && c < n)
                    begin
                        slot_stack[g][c] = SLOT_W'(s);
                        free_depth[g] = CNT_W'(c + 1);
                        r.st = ST_OK;
                    end
                end
            end
            default:
            begin
                for (g = 0; g < GROUPS; g++)
                begin
                    if (group_live[g] && (op == CMD_RCL_ALL || free_depth[g] == n))
                    begin
                        group_live[g] = 1'b0;
                        free_depth[g] = '0;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tile_result_t r;
        tile_result_t e;
        if (!rst_n)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                group_live[g] = 1'b0;
                free_depth[g] = '0;
            end
            slots_cfg = SLOTS_RESET;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            full_seen = 0;
            bad_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
                slots_cfg = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                predict_request(cmd_t'(cmd), tile_id, r);
                expected_q.push_back(r);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (status == ST_FULL)
                    full_seen++;
                if (status == ST_BAD)
                    bad_seen++;
                if (expected_q.size() == 0)
                begin
                    report($sformatf("result id %h status %0d with no request waiting",
                                     tile_id_out, status));
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (tile_id_out !== e.id)
                        report($sformatf("tile_id_out expected %h actual %h",
                                         e.id, tile_id_out));
                    if (status !== e.st)
                        report($sformatf("status expected %0d actual %0d", e.st, status));
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

[test/tile_slot_group_allocator_tb.sv]
`timescale 1ns / 100ps

module tile_slot_group_allocator_tb;
    import tsga_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam int DRAIN    = 300;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     tile_id;
    logic                out_valid;
    logic                out_stall;
    logic [ID_W-1:0]     tile_id_out;
    logic [STATUS_W-1:0] status;

    int fail_count;
    int pending;
    int results_seen;
    int full_seen;
    int bad_seen;
    int quiet_cycles;
    int cfg_writes;
    int cur_n;
    bit steady;
    logic [ID_W-1:0] returned_ids [$];

    tile_slot_group_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .tile_id     (tile_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tile_id_out (tile_id_out),
        .status      (status)
    );

    tile_slot_group_allocator_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .tile_id      (tile_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tile_id_out  (tile_id_out),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .bad_seen     (bad_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !steady && ($urandom_range(0, 99) < 18);
        end
    end

    // ids handed out by the block, reused for well-formed frees
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall && tile_id_out != 0)
        begin
            returned_ids.push_back(tile_id_out);
            if (returned_ids.size() > 256)
                void'(returned_ids.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [ID_W-1:0] make_id(input int group_field, input int slot_field);
        return {SF_W'(slot_field), GF_W'(group_field)};
    endfunction

    task automatic send(input cmd_t op, input logic [ID_W-1:0] id);
        if (!steady && $urandom_range(0, 99) < 18)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= op;
        tile_id <= id;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_setting(input logic [CFG_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
        cur_n = (value == 0) ? 1 : (value > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(value);
    endtask

    task automatic random_request(input int alloc_pct);
        int r;
        int idx;
        logic [ID_W-1:0] id;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
            send(CMD_ALLOC, ID_W'($urandom));
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60 && returned_ids.size() != 0)
            begin
                idx = $urandom_range(0, returned_ids.size() - 1);
                id = returned_ids[idx];
                // occasionally keep the id so it gets freed twice
                if ($urandom_range(0, 9) != 0)
                    returned_ids.delete(idx);
                send(CMD_FREE, id);
            end
            else if (r < 78)
                send(CMD_FREE, make_id($urandom_range(0, GROUPS_DEF + 4),
                                       $urandom_range(0, cur_n + 2)));
            else if (r < 86)
                send(CMD_FREE, ID_W'($urandom));
            else if (r < 95)
                send(CMD_RCL_EMPTY, ID_W'($urandom));
            else
                send(CMD_RCL_ALL, ID_W'($urandom));
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] value, input int items,
                             input int alloc_pct);
        write_setting(value);
        repeat (items) random_request(alloc_pct);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ALLOC;
        tile_id = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        steady = 0;
        cur_n = 16;
        cfg_writes = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting of 16 slots
        send(CMD_ALLOC, '0);
        send(CMD_ALLOC, '1);
        send(CMD_FREE, make_id(1, 16));
        send(CMD_FREE, make_id(1, 1));
        send(CMD_FREE, make_id(1, 1));
        send(CMD_FREE, make_id(0, 1));
        send(CMD_FREE, make_id(GROUPS_DEF + 1, 1));
        send(CMD_FREE, '1);
        send(CMD_FREE, make_id(2, 1));
        send(CMD_FREE, make_id(1, 0));
        send(CMD_FREE, make_id(1, 17));
        send(CMD_RCL_EMPTY, '1);
        send(CMD_ALLOC, '0);
        send(CMD_ALLOC, '0);
        send(CMD_FREE, make_id(1, 16));
        send(CMD_FREE, make_id(1, 16));
        send(CMD_ALLOC, '0);
        send(CMD_RCL_EMPTY, '0);
        send(CMD_ALLOC, '0);
        send(CMD_RCL_ALL, '1);
        send(CMD_FREE, make_id(1, 2));
        send(CMD_RCL_EMPTY, '0);

        // one slot per group: fill the table past its last group
        run_phase(9'd1, 70, 100);
        run_phase(9'd1, 30, 40);
        run_phase(9'd256, 40, 45);
        run_phase(9'd0, 30, 45);
        run_phase(9'd300, 30, 45);
        run_phase(9'd511, 20, 45);
        steady = 1;
        run_phase(9'd3, 80, 45);
        steady = 0;
        run_phase(9'd2, 40, 55);
        run_phase(CFG_W'($urandom_range(1, 40)), 40, 45);
        run_phase(9'd16, 70, 45);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("run covered %0d requests over %0d slot settings", results_seen, cfg_writes);
        $display("%0d table-full allocates and %0d rejected frees seen", full_seen, bad_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[tile_slot_group_allocator.f]
+incdir+rtl/core
rtl/core/tsga_pkg.sv
rtl/core/tsga_scan.sv
rtl/core/tsga_store.sv
rtl/core/tile_slot_group_allocator.sv
test/tile_slot_group_allocator_checker.sv
test/tile_slot_group_allocator_tb.sv
